>>> src/tcfrt_pkg.sv
`timescale 1ns / 1ps
package tcfrt_pkg;
    localparam int DEF_CHANNELS = 3;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [3:0] REG_CTRL  = 4'h0;
    localparam logic [3:0] REG_STAT  = 4'h1;
    localparam logic [3:0] REG_CNT_H = 4'h2;
    localparam logic [3:0] REG_CNT_L = 4'h3;
    localparam logic [3:0] REG_CMA_H = 4'h4;
    localparam logic [3:0] REG_CMA_L = 4'h5;
    localparam logic [3:0] REG_CMB_H = 4'h6;
    localparam logic [3:0] REG_CMB_L = 4'h7;
    localparam logic [3:0] REG_CAP_H = 4'h8;
    localparam logic [3:0] REG_CAP_L = 4'h9;

    localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] address;
        logic [7:0] write_data;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] overflow_irq;
        logic [2:0] match_a_irq;
        logic [2:0] match_b_irq;
    } t_rsp;

    function automatic logic [4:0] prescale_mask(input logic [1:0] sel, input logic variant);
        logic [4:0] m;
        case (sel)
            2'd0: m = 5'd3;
            2'd1: m = 5'd7;
            2'd2: m = 5'd31;
            default: m = variant ? 5'd3 : 5'd1;
        endcase
        return m;
    endfunction
endpackage

>>> src/tcfrt_req_if.sv
`timescale 1ns / 1ps
interface tcfrt_req_if import tcfrt_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> src/tcfrt_rsp_if.sv
`timescale 1ns / 1ps
interface tcfrt_rsp_if import tcfrt_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> src/tcfrt_cfg_if.sv
`timescale 1ns / 1ps
interface tcfrt_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/three_channel_free_running_timer_core.sv
`timescale 1ns / 1ps
// Three-channel 16-bit free-running timer behind an 8-bit register bus. Each request
// transaction is a tick, a bus read or a bus write and yields exactly one response
// transaction carrying the read byte and all nine interrupt lines as they stand after
// the request. The block takes one request per cycle: registers update at the accepting
// edge and the response is captured in the output register at that same edge, so
// throughput is one transaction per clock while the response side keeps taking them.
module three_channel_free_running_timer_core import tcfrt_pkg::*; #(
    parameter int NUM_CHANNELS = DEF_CHANNELS
) (
    input logic         i_clk,
    input logic         i_rst_n,
    tcfrt_cfg_if.sink   cfg,
    tcfrt_req_if.sink   req,
    tcfrt_rsp_if.source rsp
);
    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic       r_variant;
    logic [7:0] r_ctrl [NUM_CHANNELS];
    logic [6:0] r_stat [NUM_CHANNELS];
    logic [2:0] r_seen [NUM_CHANNELS];
    logic [15:0] r_cnt [NUM_CHANNELS];
    logic [15:0] r_cma [NUM_CHANNELS];
    logic [15:0] r_cmb [NUM_CHANNELS];
    logic [15:0] r_cap [NUM_CHANNELS];
    logic [7:0] r_latch;
    logic [4:0] r_pre;
    logic [2:0] r_irq [3];
    logic       r_valid;
    t_rsp       r_rsp;

    logic [7:0] n_ctrl [NUM_CHANNELS];
    logic [6:0] n_stat [NUM_CHANNELS];
    logic [2:0] n_seen [NUM_CHANNELS];
    logic [15:0] n_cnt [NUM_CHANNELS];
    logic [15:0] n_cma [NUM_CHANNELS];
    logic [15:0] n_cmb [NUM_CHANNELS];
    logic [15:0] n_cap [NUM_CHANNELS];
    logic [7:0] n_latch;
    logic [4:0] n_pre;
    logic [2:0] n_irq [3];
    logic [7:0] n_rd;

    logic       accept;
    logic [3:0] hi_nib;
    logic [3:0] reg_sel;
    logic [3:0] ch_full;
    logic       ch_ok;
    logic [CH_W-1:0] ch;
    logic [15:0] full_word;

    assign req.ready = !r_valid || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign rsp.valid = r_valid;
    assign rsp.payload = r_rsp;

    assign hi_nib    = req.payload.address[7:4];
    assign reg_sel   = req.payload.address[3:0];
    assign ch_full   = hi_nib - 4'd1;
    assign ch_ok     = (hi_nib != 4'd0) && (32'(ch_full) < NUM_CHANNELS);
    assign ch        = CH_W'(ch_full);
    assign full_word = {r_latch, req.payload.write_data};

    always_comb begin
        logic [15:0] v;
        logic ma, mb, clr, ovf;
        logic [7:0] data;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            n_ctrl[i] = r_ctrl[i];
            n_stat[i] = r_stat[i];
            n_seen[i] = r_seen[i];
            n_cnt[i]  = r_cnt[i];
            n_cma[i]  = r_cma[i];
            n_cmb[i]  = r_cmb[i];
            n_cap[i]  = r_cap[i];
        end
        for (int k = 0; k < 3; k++) begin
            n_irq[k] = r_irq[k];
        end
        n_latch = r_latch;
        n_pre   = r_pre;
        n_rd    = 8'd0;
        data    = req.payload.write_data;
        v = 16'd0; ma = 1'b0; mb = 1'b0; clr = 1'b0; ovf = 1'b0;
        case (req.payload.req_type)
            REQ_TICK: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if ((r_pre & prescale_mask(r_ctrl[i][1:0], r_variant)) == 5'd0) begin
                        v   = r_cnt[i];
                        ma  = v == r_cma[i];
                        mb  = v == r_cmb[i];
                        clr = r_stat[i][0] && ma;
                        ovf = !clr && (v == 16'hFFFF);
                        n_cnt[i] = clr ? 16'd0 : v + 16'd1;
                        n_stat[i][4] = r_stat[i][4] | ovf;
                        n_stat[i][5] = r_stat[i][5] | ma;
                        n_stat[i][6] = r_stat[i][6] | mb;
                        for (int k = 0; k < 3; k++) begin
                            if (r_ctrl[i][4+k] && n_stat[i][4+k]) begin
                                n_irq[k][i] = 1'b1;
                            end
                        end
                    end
                end
                n_pre = r_pre + 5'd1;
            end
            REQ_READ: begin
                if (!ch_ok) begin
                    n_rd = UNMAPPED_BYTE;
                end else begin
                    case (reg_sel)
                        REG_CTRL: n_rd = r_ctrl[ch];
                        REG_STAT: begin
                            n_rd = {1'b0, r_stat[ch]};
                            n_seen[ch] = r_seen[ch] | r_stat[ch][6:4];
                        end
                        REG_CNT_H: begin n_rd = r_cnt[ch][15:8]; n_latch = r_cnt[ch][7:0]; end
                        REG_CMA_H: begin n_rd = r_cma[ch][15:8]; n_latch = r_cma[ch][7:0]; end
                        REG_CMB_H: begin n_rd = r_cmb[ch][15:8]; n_latch = r_cmb[ch][7:0]; end
                        REG_CAP_H: begin n_rd = r_cap[ch][15:8]; n_latch = r_cap[ch][7:0]; end
                        REG_CNT_L, REG_CMA_L, REG_CMB_L, REG_CAP_L: n_rd = r_latch;
                        default: n_rd = UNMAPPED_BYTE;
                    endcase
                end
            end
            REQ_WRITE: begin
                if (ch_ok) begin
                    case (reg_sel)
                        REG_CTRL: n_ctrl[ch] = data;
                        REG_STAT: begin
                            n_stat[ch][3:0] = data[3:0];
                            for (int k = 0; k < 3; k++) begin
                                if (!data[4+k] && r_seen[ch][k]) begin
                                    n_stat[ch][4+k] = 1'b0;
                                    n_seen[ch][k]   = 1'b0;
                                    n_irq[k][ch]    = 1'b0;
                                end
                            end
                        end
                        REG_CNT_H, REG_CMA_H, REG_CMB_H, REG_CAP_H: n_latch = data;
                        REG_CNT_L: n_cnt[ch] = full_word;
                        REG_CMA_L: n_cma[ch] = full_word;
                        REG_CMB_L: n_cmb[ch] = full_word;
                        REG_CAP_L: n_cap[ch] = full_word;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= 1'b0;
            r_latch   <= 8'd0;
            r_pre     <= 5'd0;
            r_valid   <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_ctrl[i] <= '0; r_stat[i] <= '0; r_seen[i] <= '0; r_cnt[i] <= '0;
                r_cma[i]  <= '0; r_cmb[i]  <= '0; r_cap[i]  <= '0;
            end
            for (int k = 0; k < 3; k++) begin
                r_irq[k] <= '0;
            end
        end else begin
            if (cfg.valid) begin
                r_variant <= cfg.data;
            end
            if (accept) begin
                r_ctrl <= n_ctrl; r_stat <= n_stat; r_seen <= n_seen; r_cnt <= n_cnt;
                r_cma  <= n_cma;  r_cmb  <= n_cmb;  r_cap  <= n_cap;
                r_irq  <= n_irq;  r_latch <= n_latch; r_pre <= n_pre;
                r_valid <= 1'b1;
            end else if (rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp.read_data    <= n_rd;
            r_rsp.overflow_irq <= n_irq[0];
            r_rsp.match_a_irq  <= n_irq[1];
            r_rsp.match_b_irq  <= n_irq[2];
        end
    end

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !rsp.ready |=> r_valid && $stable(r_rsp))
        else $error("response changed while stalled");
    a_irq_needs_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_irq[0][0] |-> r_stat[0][4])
        else $error("overflow line up without flag");
    a_pre_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && req.payload.req_type == REQ_TICK |=> r_pre == $past(r_pre) + 5'd1)
        else $error("prescaler did not advance on tick");
endmodule

>>> sim/three_channel_free_running_timer_core_tb.sv
`timescale 1ns / 1ps
module three_channel_free_running_timer_core_tb;
    import tcfrt_pkg::*;

    localparam int NCH = 3;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tcfrt_cfg_if cfg ();
    tcfrt_req_if req ();
    tcfrt_rsp_if rsp ();

    three_channel_free_running_timer_core #(.NUM_CHANNELS(NCH)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .cfg(cfg.sink),
        .req(req.sink),
        .rsp(rsp.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // timer state as the block should hold it
    logic        tm_variant;
    logic [7:0]  tm_ctrl [NCH];
    logic [6:0]  tm_stat [NCH];
    logic [2:0]  tm_seen [NCH];
    logic [15:0] tm_cnt [NCH];
    logic [15:0] tm_cma [NCH];
    logic [15:0] tm_cmb [NCH];
    logic [15:0] tm_cap [NCH];
    logic [7:0]  tm_latch;
    logic [4:0]  tm_pre;
    logic [8:0]  tm_irq;

    t_req  pending_reqs [$];
    t_rsp  expected_rsps [$];
    logic  pending_cfg [$];
    int    error_count = 0;
    int    cycle_count = 0;
    int    req_idle = 0;
    int    rsp_stall = 0;
    bit    calm = 1'b0;
    bit    hold_req = 1'b0;

    function automatic void timer_reset();
        tm_variant = 1'b0;
        for (int i = 0; i < NCH; i++) begin
            tm_ctrl[i] = '0; tm_stat[i] = '0; tm_seen[i] = '0;
            tm_cnt[i] = '0; tm_cma[i] = '0; tm_cmb[i] = '0; tm_cap[i] = '0;
        end
        tm_latch = '0;
        tm_pre = '0;
        tm_irq = '0;
    endfunction

    function automatic void timer_tick();
        logic [4:0] m;
        logic [15:0] v;
        logic ma, mb, clr, ovf;
        for (int i = 0; i < NCH; i++) begin
            case (tm_ctrl[i][1:0])
                2'd0: m = 5'd3;
                2'd1: m = 5'd7;
                2'd2: m = 5'd31;
                default: m = tm_variant ? 5'd3 : 5'd1;
            endcase
            if ((tm_pre & m) == 0) begin
                v = tm_cnt[i];
                ma = v == tm_cma[i];
                mb = v == tm_cmb[i];
                clr = tm_stat[i][0] && ma;
                ovf = !clr && v == 16'hFFFF;
                tm_cnt[i] = clr ? 16'h0 : v + 16'h1;
                if (ovf) tm_stat[i][4] = 1'b1;
                if (ma) tm_stat[i][5] = 1'b1;
                if (mb) tm_stat[i][6] = 1'b1;
                for (int k = 0; k < 3; k++)
                    if (tm_ctrl[i][4+k] && tm_stat[i][4+k]) tm_irq[k*3+i] = 1'b1;
            end
        end
        tm_pre = tm_pre + 5'd1;
    endfunction

    function automatic logic [7:0] predict_read(input logic [7:0] a);
        int ch;
        logic [15:0] w;
        ch = int'(a[7:4]) - 1;
        if (ch < 0 || ch >= NCH) return UNMAPPED_BYTE;
        case (a[3:0])
            REG_CTRL: return tm_ctrl[ch];
            REG_STAT: begin
                tm_seen[ch] = tm_seen[ch] | tm_stat[ch][6:4];
                return {1'b0, tm_stat[ch]};
            end
            REG_CNT_H: w = tm_cnt[ch];
            REG_CMA_H: w = tm_cma[ch];
            REG_CMB_H: w = tm_cmb[ch];
            REG_CAP_H: w = tm_cap[ch];
            REG_CNT_L, REG_CMA_L, REG_CMB_L, REG_CAP_L: return tm_latch;
            default: return UNMAPPED_BYTE;
        endcase
        tm_latch = w[7:0];
        return w[15:8];
    endfunction

    function automatic void predict_write(input logic [7:0] a, input logic [7:0] d);
        int ch;
        logic [15:0] full;
        ch = int'(a[7:4]) - 1;
        full = {tm_latch, d};
        if (ch < 0 || ch >= NCH) return;
        case (a[3:0])
            REG_CTRL: tm_ctrl[ch] = d;
            REG_STAT: begin
                tm_stat[ch][3:0] = d[3:0];
                for (int k = 0; k < 3; k++)
                    if (!d[4+k] && tm_seen[ch][k]) begin
                        tm_stat[ch][4+k] = 1'b0;
                        tm_seen[ch][k] = 1'b0;
                        tm_irq[k*3+ch] = 1'b0;
                    end
            end
            REG_CNT_H, REG_CMA_H, REG_CMB_H, REG_CAP_H: tm_latch = d;
            REG_CNT_L: tm_cnt[ch] = full;
            REG_CMA_L: tm_cma[ch] = full;
            REG_CMB_L: tm_cmb[ch] = full;
            REG_CAP_L: tm_cap[ch] = full;
            default: ;
        endcase
    endfunction

    function automatic t_rsp predict_item(input t_req r);
        t_rsp o;
        o.read_data = 8'h00;
        case (r.req_type)
            REQ_TICK: timer_tick();
            REQ_READ: o.read_data = predict_read(r.address);
            REQ_WRITE: predict_write(r.address, r.write_data);
            default: ;
        endcase
        o.overflow_irq = tm_irq[2:0];
        o.match_a_irq = tm_irq[5:3];
        o.match_b_irq = tm_irq[8:6];
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req.valid <= 1'b0;
            req.payload <= '0;
        end else if (!req.valid || req.ready) begin
            if (req.valid) expected_rsps.push_back(predict_item(req.payload));
            if (req_idle > 0) begin
                req_idle--;
                req.valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !hold_req) begin
                req.valid <= 1'b1;
                req.payload <= pending_reqs.pop_front();
                if (!calm && $urandom_range(0, 9) == 0) req_idle = $urandom_range(1, 19);
            end else begin
                req.valid <= 1'b0;
            end
        end
    end

    // configuration driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.valid <= 1'b0;
            cfg.data <= 1'b0;
        end else if (cfg.valid && cfg.ready) begin
            tm_variant = cfg.data;
            cfg.valid <= 1'b0;
        end else if (!cfg.valid && pending_cfg.size() > 0) begin
            cfg.valid <= 1'b1;
            cfg.data <= pending_cfg.pop_front();
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            rsp.ready <= 1'b0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch("unexpected transaction", rsp.payload.read_data, 8'h0);
                end else begin
                    want = expected_rsps.pop_front();
                    if (rsp.payload.read_data !== want.read_data)
                        report_mismatch("read_data", rsp.payload.read_data, want.read_data);
                    if (rsp.payload.overflow_irq !== want.overflow_irq)
                        report_mismatch("overflow_irq", rsp.payload.overflow_irq,
                                        want.overflow_irq);
                    if (rsp.payload.match_a_irq !== want.match_a_irq)
                        report_mismatch("match_a_irq", rsp.payload.match_a_irq,
                                        want.match_a_irq);
                    if (rsp.payload.match_b_irq !== want.match_b_irq)
                        report_mismatch("match_b_irq", rsp.payload.match_b_irq,
                                        want.match_b_irq);
                end
            end
            if (rsp_stall > 0) begin
                rsp_stall--;
                rsp.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                rsp_stall = $urandom_range(1, 19);
                rsp.ready <= 1'b0;
            end else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_req mk(input logic [1:0] t, input logic [7:0] a, input logic [7:0] d);
        t_req r;
        r.req_type = t; r.address = a; r.write_data = d;
        return r;
    endfunction

    function automatic logic [7:0] rand_addr();
        logic [3:0] reg_n;
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        reg_n = 4'($urandom_range(0, 9));
        return {4'($urandom_range(1, 3)), reg_n};
    endfunction

    task automatic queue_word(input logic [7:0] base, input logic [3:0] hi_reg,
                              input logic [15:0] val);
        pending_reqs.push_back(mk(REQ_WRITE, base | 8'(hi_reg), val[15:8]));
        pending_reqs.push_back(mk(REQ_WRITE, base | 8'(hi_reg + 4'd1), val[7:0]));
    endtask

    task automatic queue_phase(input int n);
        logic [7:0] base;
        int kind;
        repeat (n) begin
            kind = $urandom_range(0, 19);
            base = {4'($urandom_range(1, 3)), 4'h0};
            if (kind < 9) begin
                pending_reqs.push_back(mk(REQ_TICK, 8'($urandom), 8'($urandom)));
            end else if (kind < 11) begin
                // flag clear sequence: read status then write flags to zero
                pending_reqs.push_back(mk(REQ_READ, base | 8'(REG_STAT), 8'h0));
                pending_reqs.push_back(mk(REQ_WRITE, base | 8'(REG_STAT),
                                          8'($urandom) & 8'h8F));
            end else if (kind < 13) begin
                pending_reqs.push_back(mk(REQ_READ, base | 8'($urandom_range(0, 4) * 2 + 2),
                                          8'h0));
                pending_reqs.push_back(mk(REQ_READ, base | 8'($urandom_range(1, 4) * 2 + 1),
                                          8'h0));
            end else if (kind == 13) begin
                queue_word(base, REG_CMA_H, 16'($urandom_range(0, 40)));
            end else if (kind == 14) begin
                queue_word(base, REG_CMB_H, 16'($urandom_range(0, 40)));
            end else if (kind == 15) begin
                queue_word(base, REG_CNT_H, $urandom_range(0, 3) == 0 ? 16'hFFF0
                                                                   : 16'($urandom));
            end else if (kind == 16) begin
                pending_reqs.push_back(mk(REQ_WRITE, base | 8'(REG_CTRL), 8'($urandom)));
            end else if (kind == 17) begin
                pending_reqs.push_back(mk(2'($urandom_range(1, 3)), rand_addr(),
                                          8'($urandom)));
            end else begin
                pending_reqs.push_back(mk(REQ_READ, rand_addr(), 8'h0));
            end
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        timer_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, unmapped space, wrap and clear on match
        pending_reqs.push_back(mk(REQ_READ, 8'h05, 8'h0));
        pending_reqs.push_back(mk(REQ_WRITE, 8'h00, 8'hFF));
        pending_reqs.push_back(mk(REQ_READ, 8'h4F, 8'h0));
        pending_reqs.push_back(mk(REQ_READ, 8'h1A, 8'h0));
        pending_reqs.push_back(mk(REQ_WRITE, 8'hFF, 8'hAA));
        pending_reqs.push_back(mk(2'd3, 8'h13, 8'h55));
        pending_reqs.push_back(mk(REQ_WRITE, 8'h10, 8'h73));
        pending_reqs.push_back(mk(REQ_WRITE, 8'h11, 8'h01));
        queue_word(8'h10, REG_CMA_H, 16'hFFFF);
        queue_word(8'h10, REG_CNT_H, 16'hFFFE);
        queue_word(8'h20, REG_CNT_H, 16'hFFFF);
        pending_reqs.push_back(mk(REQ_WRITE, 8'h20, 8'h10));
        queue_word(8'h30, REG_CAP_H, 16'hA55A);
        pending_reqs.push_back(mk(REQ_READ, 8'h38, 8'h0));
        pending_reqs.push_back(mk(REQ_READ, 8'h39, 8'h0));
        repeat (4) pending_reqs.push_back(mk(REQ_TICK, 8'hFF, 8'hFF));
        pending_reqs.push_back(mk(REQ_READ, 8'h11, 8'h0));
        pending_reqs.push_back(mk(REQ_WRITE, 8'h11, 8'h0F));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            pending_cfg.push_back(ph[0]);
            while (pending_cfg.size() > 0 || cfg.valid) @(posedge i_clk);
            queue_phase(130);
            drain();
        end
        // pause the sender until all responses are in
        queue_phase(60);
        repeat (40) @(posedge i_clk);
        hold_req = 1'b1;
        while (expected_rsps.size() > 0 || req.valid) @(posedge i_clk);
        hold_req = 1'b0;
        drain();
        calm = 1'b1;
        queue_phase(100);
        drain();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
